### rtl/core/jcdt_pkg.sv
// jcdt_pkg: shared types, codes and widths for the job chunk dependency tracker
// no dependencies; used by jcdt_ctrl, jcdt_datapath and the top level
`default_nettype none

package jcdt_pkg;

	// fixed field widths
	localparam int ID_W    = 11;
	localparam int TIME_W  = 48;
	localparam int DL_W    = 32;
	localparam int LIMIT_W = 42;
	localparam int ST_W    = 3;
	localparam int IDENT_W = 32;
	localparam int MASK_W  = 32;
	localparam int CHUNK_SHIFT = 16;

	localparam logic [ID_W-1:0] FIRST_ID = 11'd1001;

	// parameter defaults
	localparam int MAX_JOBS_DEF       = 32;
	localparam int CHUNKS_PER_JOB_DEF = 3;

	typedef enum logic [1:0] {
		ACT_SUBMIT = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_CHUNK  = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [ST_W-1:0] {
		JS_SUBMITTED = 3'd0,
		JS_PLANNING  = 3'd1,
		JS_EXECUTING = 3'd2,
		JS_COMPLETED = 3'd3,
		JS_FAILED    = 3'd4,
		JS_CANCELLED = 3'd5
	} job_state_t;

	typedef enum logic [ST_W-1:0] {
		CS_PENDING   = 3'd0,
		CS_READY     = 3'd1,
		CS_RUNNING   = 3'd2,
		CS_COMPLETED = 3'd3,
		CS_FAILED    = 3'd4
	} chunk_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_CHECK,
		ST_CMP,
		ST_FINISH
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic submit;
		logic rd;
		logic check;
		logic cmp;
		logic step;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t act;
		logic    empty;
		logic    last;
		logic    hit;
		logic    out_free;
	} stat_t;

endpackage

`default_nettype wire

### rtl/core/jcdt_ctrl.sv
// jcdt_ctrl: sequencer that walks the job slots for cancel, chunk result and tick actions
// depends on jcdt_pkg
`default_nettype none

module jcdt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  jcdt_pkg::stat_t     stat,
	output jcdt_pkg::cmd_t      cmd
);

	jcdt_pkg::ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jcdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != jcdt_pkg::ST_IDLE);
		unique case (state_q)
			jcdt_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = jcdt_pkg::ST_START;
				end
			end
			jcdt_pkg::ST_START: begin
				if (stat.act == jcdt_pkg::ACT_SUBMIT) begin
					cmd.submit = 1'b1;
					state_d    = jcdt_pkg::ST_FINISH;
				end else if (stat.empty) begin
					state_d = jcdt_pkg::ST_FINISH;
				end else begin
					state_d = jcdt_pkg::ST_READ;
				end
			end
			jcdt_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = jcdt_pkg::ST_CHECK;
			end
			jcdt_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				if (stat.act == jcdt_pkg::ACT_TICK) begin
					state_d = jcdt_pkg::ST_CMP;
				end else if (stat.hit || stat.last) begin
					state_d = jcdt_pkg::ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					state_d  = jcdt_pkg::ST_READ;
				end
			end
			jcdt_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				if (stat.last) begin
					state_d = jcdt_pkg::ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					state_d  = jcdt_pkg::ST_READ;
				end
			end
			jcdt_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = jcdt_pkg::ST_IDLE;
				end
			end
			default: state_d = jcdt_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/jcdt_datapath.sv
// jcdt_datapath: slot tables, chunk rows, time compare and result registers
// depends on jcdt_pkg; driven by jcdt_ctrl
`default_nettype none

module jcdt_datapath #(
	parameter int MAX_JOBS       = jcdt_pkg::MAX_JOBS_DEF,
	parameter int CHUNKS_PER_JOB = jcdt_pkg::CHUNKS_PER_JOB_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  jcdt_pkg::cmd_t                         cmd,
	output jcdt_pkg::stat_t                        stat,
	input  wire logic [1:0]                        action,
	input  wire logic                              splittable,
	input  wire logic [jcdt_pkg::DL_W-1:0]         deadline_s,
	input  wire logic [jcdt_pkg::TIME_W-1:0]       now_ms,
	input  wire logic [jcdt_pkg::IDENT_W-1:0]      job_ident,
	input  wire logic [jcdt_pkg::IDENT_W-1:0]      chunk_ident,
	input  wire logic [jcdt_pkg::ST_W-1:0]         chunk_result,
	input  wire logic                              out_stall,
	output logic                                   out_valid,
	output logic                                   ok,
	output logic [jcdt_pkg::ID_W-1:0]              new_id,
	output logic [jcdt_pkg::ST_W-1:0]              job_status,
	output logic [1:0]                             done_count,
	output logic [jcdt_pkg::MASK_W-1:0]            expired_mask
);

	localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W  = $clog2(MAX_JOBS + 1);
	localparam int CHK_W  = (CHUNKS_PER_JOB > 1) ? $clog2(CHUNKS_PER_JOB) : 1;
	localparam int DONE_W = $clog2(CHUNKS_PER_JOB + 1);
	localparam int ROW_W  = CHUNKS_PER_JOB * jcdt_pkg::ST_W;
	localparam int ST_W   = jcdt_pkg::ST_W;

	// captured request
	jcdt_pkg::action_t                act_q;
	logic                             split_q;
	logic [jcdt_pkg::DL_W-1:0]        dl_q;
	logic [jcdt_pkg::TIME_W-1:0]      now_q;
	logic [jcdt_pkg::IDENT_W-1:0]     job_q;
	logic [jcdt_pkg::IDENT_W-1:0]     chunk_q;
	logic [ST_W-1:0]                  res_q;

	// control counters
	logic [CNT_W-1:0]                 count_q;
	logic [jcdt_pkg::ID_W-1:0]        next_id_q;
	logic [SLOT_W-1:0]                idx_q;

	// slot tables
	logic [jcdt_pkg::ID_W-1:0]        id_mem    [MAX_JOBS];
	logic [ST_W-1:0]                  status_mem[MAX_JOBS];
	logic [jcdt_pkg::TIME_W-1:0]      start_mem [MAX_JOBS];
	logic [jcdt_pkg::DL_W-1:0]        dl_mem    [MAX_JOBS];
	logic [ROW_W-1:0]                 row_mem   [MAX_JOBS];

	logic [jcdt_pkg::ID_W-1:0]        id_rd_q;
	logic [ST_W-1:0]                  status_rd_q;
	logic [jcdt_pkg::TIME_W-1:0]      start_rd_q;
	logic [jcdt_pkg::DL_W-1:0]        dl_rd_q;
	logic [ROW_W-1:0]                 row_rd_q;

	// tick compare stage
	logic [jcdt_pkg::TIME_W-1:0]      elapsed_s2;
	logic [jcdt_pkg::LIMIT_W-1:0]     limit_s2;
	logic                             exec_s2;

	// result and output registers
	logic                             r_ok_q;
	logic [jcdt_pkg::ID_W-1:0]        r_aid_q;
	logic [ST_W-1:0]                  r_jst_q;
	logic [1:0]                       r_done_q;
	logic [jcdt_pkg::MASK_W-1:0]      r_mask_q;
	logic                             out_valid_q;
	logic                             ok_q;
	logic [jcdt_pkg::ID_W-1:0]        aid_q;
	logic [ST_W-1:0]                  jst_q;
	logic [1:0]                       done_q;
	logic [jcdt_pkg::MASK_W-1:0]      mask_q;

	// combinational decode
	logic                             submit_ok;
	logic                             id_hit;
	logic                             chunk_hit;
	logic [CHK_W-1:0]                 cix;
	logic [ROW_W-1:0]                 row_set;
	logic [ROW_W-1:0]                 row_new;
	logic [ROW_W-1:0]                 row_init;
	logic                             any_failed;
	logic [DONE_W-1:0]                done_new;
	logic [DONE_W-1:0]                done_old;
	logic [ST_W-1:0]                  jst_new;
	logic                             expired;
	logic [jcdt_pkg::MASK_W-1:0]      mask_one;
	logic [SLOT_W-1:0]                wr_addr;

	assign submit_ok = split_q && (count_q < CNT_W'(MAX_JOBS));
	assign id_hit    = (job_q[jcdt_pkg::IDENT_W-1:jcdt_pkg::ID_W] == '0) &&
	                   (job_q[jcdt_pkg::ID_W-1:0] == id_rd_q);
	assign chunk_hit = id_hit &&
	                   (chunk_q[jcdt_pkg::IDENT_W-1:jcdt_pkg::CHUNK_SHIFT] ==
	                    16'(id_rd_q)) &&
	                   (chunk_q[jcdt_pkg::CHUNK_SHIFT-1:0] < 16'(CHUNKS_PER_JOB));
	assign cix       = chunk_q[CHK_W-1:0];
	assign expired   = exec_s2 && (elapsed_s2 >= jcdt_pkg::TIME_W'(limit_s2));
	assign mask_one  = jcdt_pkg::MASK_W'(1) << idx_q;
	assign wr_addr   = cmd.submit ? count_q[SLOT_W-1:0] : idx_q;

	// chunk row update: write result, promote pending chunks, recount
	always_comb begin
		row_set    = row_rd_q;
		row_new    = '0;
		row_init   = '0;
		any_failed = 1'b0;
		done_new   = '0;
		done_old   = '0;
		for (int c = 0; c < CHUNKS_PER_JOB; c++) begin
			if (CHK_W'(c) == cix) begin
				row_set[c*ST_W +: ST_W] = res_q;
			end
		end
		for (int c = 0; c < CHUNKS_PER_JOB; c++) begin
			row_new[c*ST_W +: ST_W] = row_set[c*ST_W +: ST_W];
			if (row_set[c*ST_W +: ST_W] == jcdt_pkg::CS_PENDING) begin
				if (c == 0) begin
					row_new[c*ST_W +: ST_W] = jcdt_pkg::CS_READY;
				end else if (row_set[(c-1)*ST_W +: ST_W] == jcdt_pkg::CS_COMPLETED) begin
					row_new[c*ST_W +: ST_W] = jcdt_pkg::CS_READY;
				end
			end
		end
		for (int c = 0; c < CHUNKS_PER_JOB; c++) begin
			if (row_new[c*ST_W +: ST_W] == jcdt_pkg::CS_FAILED) begin
				any_failed = 1'b1;
			end
			if (row_new[c*ST_W +: ST_W] == jcdt_pkg::CS_COMPLETED) begin
				done_new = done_new + DONE_W'(1);
			end
			if (row_rd_q[c*ST_W +: ST_W] == jcdt_pkg::CS_COMPLETED) begin
				done_old = done_old + DONE_W'(1);
			end
		end
		row_init[ST_W-1:0] = jcdt_pkg::CS_READY;
		if (any_failed) begin
			jst_new = jcdt_pkg::JS_FAILED;
		end else if (done_new == DONE_W'(CHUNKS_PER_JOB)) begin
			jst_new = jcdt_pkg::JS_COMPLETED;
		end else begin
			jst_new = status_rd_q;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= jcdt_pkg::action_t'(action);
			split_q <= splittable;
			dl_q    <= deadline_s;
			now_q   <= now_ms;
			job_q   <= job_ident;
			chunk_q <= chunk_ident;
			res_q   <= chunk_result;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_id_q <= jcdt_pkg::FIRST_ID;
			idx_q     <= '0;
		end else begin
			if (cmd.submit && submit_ok) begin
				count_q   <= count_q + CNT_W'(1);
				next_id_q <= next_id_q + jcdt_pkg::ID_W'(1);
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end
	end

	// slot table writes
	always_ff @(posedge clk) begin
		if (cmd.submit && submit_ok) begin
			id_mem[wr_addr]    <= next_id_q;
			start_mem[wr_addr] <= now_q;
			dl_mem[wr_addr]    <= dl_q;
			row_mem[wr_addr]   <= row_init;
			status_mem[wr_addr] <= jcdt_pkg::JS_EXECUTING;
		end else if (cmd.check && act_q == jcdt_pkg::ACT_CANCEL && id_hit) begin
			status_mem[wr_addr] <= jcdt_pkg::JS_CANCELLED;
		end else if (cmd.check && act_q == jcdt_pkg::ACT_CHUNK && chunk_hit) begin
			status_mem[wr_addr] <= jst_new;
			row_mem[wr_addr]    <= row_new;
		end else if (cmd.cmp && expired) begin
			status_mem[wr_addr] <= jcdt_pkg::JS_FAILED;
		end
	end

	// slot table read, registered
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			id_rd_q     <= id_mem[idx_q];
			status_rd_q <= status_mem[idx_q];
			start_rd_q  <= start_mem[idx_q];
			dl_rd_q     <= dl_mem[idx_q];
			row_rd_q    <= row_mem[idx_q];
		end
	end

	// elapsed time and deadline in ms (times 1000 as shift and subtract)
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			elapsed_s2 <= now_q - start_rd_q;
			limit_s2   <= {dl_rd_q, 10'b0} - {6'b0, dl_rd_q, 4'b0} -
			              {7'b0, dl_rd_q, 3'b0};
			exec_s2    <= (status_rd_q == jcdt_pkg::JS_EXECUTING);
		end
	end

	// result accumulation
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_ok_q   <= (jcdt_pkg::action_t'(action) == jcdt_pkg::ACT_TICK);
			r_aid_q  <= '0;
			r_jst_q  <= '0;
			r_done_q <= '0;
			r_mask_q <= '0;
		end else if (cmd.submit) begin
			if (submit_ok) begin
				r_ok_q  <= 1'b1;
				r_aid_q <= next_id_q;
				r_jst_q <= jcdt_pkg::JS_EXECUTING;
			end
		end else if (cmd.check && act_q == jcdt_pkg::ACT_CANCEL && id_hit) begin
			r_ok_q   <= 1'b1;
			r_jst_q  <= jcdt_pkg::JS_CANCELLED;
			r_done_q <= done_old[1:0];
		end else if (cmd.check && act_q == jcdt_pkg::ACT_CHUNK && chunk_hit) begin
			r_ok_q   <= 1'b1;
			r_jst_q  <= jst_new;
			r_done_q <= done_new[1:0];
		end else if (cmd.cmp && expired) begin
			r_mask_q <= r_mask_q | mask_one;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ok_q   <= r_ok_q;
			aid_q  <= r_aid_q;
			jst_q  <= r_jst_q;
			done_q <= r_done_q;
			mask_q <= r_mask_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign new_id       = aid_q;
	assign job_status   = jst_q;
	assign done_count   = done_q;
	assign expired_mask = mask_q;

	// status to controller
	assign stat.act      = act_q;
	assign stat.empty    = (count_q == '0);
	assign stat.last     = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign stat.hit      = (act_q == jcdt_pkg::ACT_CANCEL) ? id_hit : chunk_hit;
	assign stat.out_free = !out_valid_q || !out_stall;

	// checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_JOBS))
		else $error("job count beyond table size");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.submit && submit_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted submit did not take a slot");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

### rtl/core/job_chunk_dependency_tracker.sv
// job_chunk_dependency_tracker: top level, joins sequencer and datapath
// depends on jcdt_pkg, jcdt_ctrl, jcdt_datapath
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    action splittable deadline_s now_ms
//                                            job_ident chunk_ident chunk_result
// out      source     out_valid / out_stall  ok new_id job_status done_count
//                                            expired_mask
//
// submit passes START and FINISH from transfer to the output register; with no jobs any action does too.
// cancel and chunk result read one slot per READ and CHECK pair until a match or the last slot.
// tick reads and compares each slot in READ, CHECK and CMP over all jobs.
// the single-port slot table read and the time compare stage set these steps; FINISH waits on out_stall.
// reset clears the job count and the result valid and sets the id counter to FIRST_ID; no clearing pass.
// a new item transfers while a finished result still waits under out_stall.
`default_nettype none

module job_chunk_dependency_tracker #(
	parameter int MAX_JOBS       = jcdt_pkg::MAX_JOBS_DEF,
	parameter int CHUNKS_PER_JOB = jcdt_pkg::CHUNKS_PER_JOB_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    action,
	input  wire logic                          splittable,
	input  wire logic [jcdt_pkg::DL_W-1:0]     deadline_s,
	input  wire logic [jcdt_pkg::TIME_W-1:0]   now_ms,
	input  wire logic [jcdt_pkg::IDENT_W-1:0]  job_ident,
	input  wire logic [jcdt_pkg::IDENT_W-1:0]  chunk_ident,
	input  wire logic [jcdt_pkg::ST_W-1:0]     chunk_result,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               ok,
	output logic [jcdt_pkg::ID_W-1:0]          new_id,
	output logic [jcdt_pkg::ST_W-1:0]          job_status,
	output logic [1:0]                         done_count,
	output logic [jcdt_pkg::MASK_W-1:0]        expired_mask
);

	jcdt_pkg::cmd_t  cmd;
	jcdt_pkg::stat_t stat;

	// sequencer
	jcdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tables and result path
	jcdt_datapath #(
		.MAX_JOBS       (MAX_JOBS),
		.CHUNKS_PER_JOB (CHUNKS_PER_JOB)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.splittable   (splittable),
		.deadline_s   (deadline_s),
		.now_ms       (now_ms),
		.job_ident    (job_ident),
		.chunk_ident  (chunk_ident),
		.chunk_result (chunk_result),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.ok           (ok),
		.new_id       (new_id),
		.job_status   (job_status),
		.done_count   (done_count),
		.expired_mask (expired_mask)
	);

endmodule

`default_nettype wire
